// ===== src/ctc_greedy_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// ctc greedy decoder assertion macros
// shared property wrappers for the port-level checker
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_DECODER_DEFINES_SVH
`define CTC_GREEDY_DECODER_DEFINES_SVH

// clocked property, masked while reset is high
`define CTCGD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ctc greedy decoder assertion failed");

// clocked property that also holds through reset
`define CTCGD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ctc greedy decoder assertion failed");

`endif

// ===== src/ctcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder package
// shared constants, register codes and queue status type
// ----------------------------------------------------------------------------
package ctcgd_pkg;

   // configuration port
   localparam int CFG_W      = 14;
   localparam int CFG_ADDR_W = 1;

   // register indexes
   typedef enum logic [CFG_ADDR_W-1:0] {
      REG_CLASS_COUNT = 1'b0,
      REG_KEY_COUNT   = 1'b1
   } csr_reg_type;

   // register reset values
   localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = 14'd1;
   localparam logic [CFG_W-1:0] KEY_COUNT_RESET   = 14'd0;

   // parameter defaults
   localparam int DEF_MAX_CLASSES = 8192;
   localparam int DEF_MAX_STEPS   = 1024;
   localparam int DEF_SCORE_WIDTH = 16;

   // step queue depth between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== src/ctcgd_front.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder front
// one score per cycle unless the queue is full; tracks the running maximum and
// pushes a step record (winner, best score, last flag) when the step closes
// ----------------------------------------------------------------------------
module ctcgd_front
   import ctcgd_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int SCORE_WIDTH = DEF_SCORE_WIDTH,
   parameter int IDX_W       = $clog2(MAX_CLASSES),
   parameter int REQ_DATA_W  = ((SCORE_WIDTH + 7) / 8) * 8,
   parameter int REC_W       = IDX_W + SCORE_WIDTH + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CFG_W-1:0]      class_count,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  queue_status_type      q_status,
   output logic                  push,
   output logic [REC_W-1:0]      push_data
);

   localparam int CMP_W = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
   localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_CLASSES);

   logic [IDX_W-1:0]              cnt_ff, cnt_in;
   logic signed [SCORE_WIDTH-1:0] max_ff, max_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;

   logic                          accept;
   logic signed [SCORE_WIDTH-1:0] score;
   logic [CMP_W-1:0]              cc_ext;
   logic [CMP_W-1:0]              last_wide;
   logic [IDX_W-1:0]              last_idx;
   logic                          take;
   logic                          done;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign score      = signed'(req_tdata[SCORE_WIDTH-1:0]);

   // index of the last class of a step, count clamped to 1..MAX_CLASSES
   always_comb begin
      cc_ext = CMP_W'(class_count);
      if (cc_ext == '0) begin
         last_wide = '0;
      end else if (cc_ext > MAX_C) begin
         last_wide = MAX_C - CMP_W'(1);
      end else begin
         last_wide = cc_ext - CMP_W'(1);
      end
      last_idx = last_wide[IDX_W-1:0];
   end

   // running maximum, first class wins a tie
   always_comb begin
      take   = (cnt_ff == '0) || (score > max_ff);
      max_in = take ? score : max_ff;
      idx_in = take ? cnt_ff : idx_ff;
      done   = req_tlast || (cnt_ff >= last_idx);
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = done ? '0 : cnt_ff + IDX_W'(1);
      end
   end

   // step record to the queue
   assign push      = accept && done;
   assign push_data = {req_tlast, max_in, idx_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         max_ff <= max_in;
         idx_ff <= idx_in;
      end
   end

endmodule

// ===== src/ctcgd_queue.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder step queue
// small first-in first-out buffer of closed-step records
// ----------------------------------------------------------------------------
module ctcgd_queue
   import ctcgd_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   assign q_status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/ctcgd_back.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder back
// judges each closed step against the previous winner and the key count,
// counts steps and holds the result item in an output register
// ----------------------------------------------------------------------------
module ctcgd_back
   import ctcgd_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int MAX_STEPS   = DEF_MAX_STEPS,
   parameter int SCORE_WIDTH = DEF_SCORE_WIDTH,
   parameter int IDX_W       = $clog2(MAX_CLASSES),
   parameter int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
   parameter int REC_W       = IDX_W + SCORE_WIDTH + 1,
   parameter int RSP_DATA_W  = ((IDX_W + SCORE_WIDTH + STEP_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CFG_W-1:0]      key_count,
   input  queue_status_type      q_status,
   input  logic [REC_W-1:0]      pop_data,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int CMP_W   = (IDX_W > CFG_W) ? IDX_W : CFG_W;
   localparam int PAY_W   = IDX_W + SCORE_WIDTH + STEP_W;
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_STEPS - 1);

   logic                   valid_ff, valid_in;
   logic                   char_ff, char_in;
   logic                   end_ff, end_in;
   logic [PAY_W-1:0]       pay_ff, pay_in;
   logic [IDX_W-1:0]       prev_ff, prev_in;
   logic [STEP_W-1:0]      step_ff, step_in;

   logic                   h_last;
   logic [SCORE_WIDTH-1:0] h_best;
   logic [IDX_W-1:0]       h_idx;
   logic                   emit;
   logic                   produce;

   // head record of the queue
   assign h_last = pop_data[REC_W-1];
   assign h_best = pop_data[REC_W-2 -: SCORE_WIDTH];
   assign h_idx  = pop_data[IDX_W-1:0];

   // character rule: not blank, inside the key range, not a repeat
   always_comb begin
      emit = (h_idx != '0)
          && (CMP_W'(h_idx) < CMP_W'(key_count))
          && (h_idx != prev_ff);
      produce = emit || h_last;
      pop = !q_status.empty && (!produce || !valid_ff || rsp_tready);
   end

   // output register and decode state
   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      char_in  = char_ff;
      end_in   = end_ff;
      pay_in   = pay_ff;
      prev_in  = prev_ff;
      step_in  = step_ff;
      if (pop) begin
         if (produce) begin
            valid_in = 1'b1;
            char_in  = emit;
            end_in   = h_last;
            pay_in   = emit ? {step_ff, h_best, h_idx} : '0;
         end
         if (h_last) begin
            prev_in = '0;
            step_in = '0;
         end else begin
            prev_in = h_idx;
            if (step_ff != STEP_MAX) begin
               step_in = step_ff + STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         prev_ff  <= '0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         prev_ff  <= prev_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      end_ff  <= end_in;
      pay_ff  <= pay_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = char_ff;
   assign rsp_tlast  = end_ff;
   assign rsp_tdata  = RSP_DATA_W'(pay_ff);

endmodule

// ===== src/ctc_greedy_decoder.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder top level
// best-path decoding of a class score stream into key indices
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: score; tlast: end_of_sequence
//   rsp      out  rsp_tvalid/rsp_tready  tdata: key_index, best_score,
//                                        step_index; tuser: char_valid;
//                                        tlast: sequence_end
//   csr      in   csr_we                 csr_addr, csr_wdata
//
// one score is taken every cycle unless the step queue is full; a closed step
// reaches rsp through the front compare, step queue and back output register
// throughput is set by the single front compare, one item per cycle while the
// queue has room; the queue lets the front run on while a result waits at rsp
// reset is synchronous and clears counters, queue and output valid
// ----------------------------------------------------------------------------
module ctc_greedy_decoder
   import ctcgd_pkg::*;
#(
   parameter int MAX_CLASSES = DEF_MAX_CLASSES,
   parameter int MAX_STEPS   = DEF_MAX_STEPS,
   parameter int SCORE_WIDTH = DEF_SCORE_WIDTH,
   parameter int IDX_W       = $clog2(MAX_CLASSES),
   parameter int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1,
   parameter int REQ_DATA_W  = ((SCORE_WIDTH + 7) / 8) * 8,
   parameter int RSP_DATA_W  = ((IDX_W + SCORE_WIDTH + STEP_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CFG_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   // scores
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // score
   input  logic                  req_tlast,
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // key_index, best_score, step_index
   output logic                  rsp_tuser,   // char_valid
   output logic                  rsp_tlast
);

   localparam int REC_W = IDX_W + SCORE_WIDTH + 1;

   logic [CFG_W-1:0]  class_count_ff, class_count_in;
   logic [CFG_W-1:0]  key_count_ff, key_count_in;

   logic              push;
   logic [REC_W-1:0]  push_data;
   logic              pop;
   logic [REC_W-1:0]  pop_data;
   queue_status_type  q_status;

   // configuration register decode
   always_comb begin
      class_count_in = class_count_ff;
      key_count_in   = key_count_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_CLASS_COUNT: class_count_in = csr_wdata;
            REG_KEY_COUNT:   key_count_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff <= CLASS_COUNT_RESET;
         key_count_ff   <= KEY_COUNT_RESET;
      end else begin
         class_count_ff <= class_count_in;
         key_count_ff   <= key_count_in;
      end
   end

   // score compare and step close
   ctcgd_front #(
      .MAX_CLASSES (MAX_CLASSES),
      .SCORE_WIDTH (SCORE_WIDTH),
      .IDX_W       (IDX_W),
      .REQ_DATA_W  (REQ_DATA_W),
      .REC_W       (REC_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .class_count (class_count_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   // closed steps waiting for the back
   ctcgd_queue #(
      .WIDTH (REC_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // character decision and result register
   ctcgd_back #(
      .MAX_CLASSES (MAX_CLASSES),
      .MAX_STEPS   (MAX_STEPS),
      .SCORE_WIDTH (SCORE_WIDTH),
      .IDX_W       (IDX_W),
      .STEP_W      (STEP_W),
      .REC_W       (REC_W),
      .RSP_DATA_W  (RSP_DATA_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .key_count  (key_count_ff),
      .q_status   (q_status),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/ctcgd_checker.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder port checker
// watches the result channel of the top level over time
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_defines.svh"

module ctcgd_checker
   import ctcgd_pkg::*;
#(
   parameter int IDX_W      = $clog2(DEF_MAX_CLASSES),
   parameter int RSP_DATA_W = 40
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser,
   input logic                  rsp_tlast
);

   // no result is shown in the cycle after a reset cycle
   `CTCGD_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // a stalled result holds its payload
   `CTCGD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // a result without a character only closes a sequence and carries zeros
   `CTCGD_ASSERT(a_empty_close, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))

   // a character is never the blank class
   `CTCGD_ASSERT(a_no_blank, clock, reset, rsp_tvalid && rsp_tuser |-> (rsp_tdata[IDX_W-1:0] != '0))

endmodule

bind ctc_greedy_decoder ctcgd_checker #(
   .IDX_W      (IDX_W),
   .RSP_DATA_W (RSP_DATA_W)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/ctc_greedy_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// ctc greedy decoder testbench
// streams class scores through the decoder and checks every result item
// against a cycle-free best-path predictor kept in the bench; runs directed
// steps and random sequences under several class and key counts
// ----------------------------------------------------------------------------
module ctc_greedy_decoder_tb;
   import ctcgd_pkg::*;

   localparam int IDX_W      = $clog2(DEF_MAX_CLASSES);
   localparam int STEP_W     = $clog2(DEF_MAX_STEPS);
   localparam int SCORE_W    = DEF_SCORE_WIDTH;
   localparam int REQ_DATA_W = ((SCORE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((IDX_W + SCORE_W + STEP_W + 7) / 8) * 8;
   localparam int SETTLE     = 8;
   localparam int RANDOM_ITEMS = 400;

   // one decoded character or end marker, fields as carried on rsp
   typedef struct packed {
      logic                      char_valid;
      logic [IDX_W-1:0]          key_index;
      logic signed [SCORE_W-1:0] best_score;
      logic [STEP_W-1:0]         step_index;
      logic                      seq_end;
   } char_result_type;

   typedef struct {
      logic [SCORE_W-1:0] score;
      logic               last;
      logic               hold;
   } score_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CFG_ADDR_W-1:0] csr_addr = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // score
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // key_index, best_score, step_index
   logic                  rsp_tuser;        // char_valid
   logic                  rsp_tlast;

   ctc_greedy_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stimulus and expectations
   score_item_type  score_q[$];
   char_result_type pending_chars[$];
   int              errors = 0;
   int              pushed_items = 0;

   // decoder image: configuration and per-sequence state
   logic [CFG_W-1:0]          class_cfg = CLASS_COUNT_RESET;
   logic [CFG_W-1:0]          key_cfg   = KEY_COUNT_RESET;
   int                        class_ctr = 0;
   logic signed [SCORE_W-1:0] step_max  = {1'b1, {(SCORE_W-1){1'b0}}};
   int                        step_win  = 0;
   int                        prev_win  = 0;
   int                        step_ctr  = 0;

   function automatic int eff_classes(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DEF_MAX_CLASSES) return DEF_MAX_CLASSES;
      return int'(v);
   endfunction

   // best-path update for one accepted score
   function automatic void decode_score(logic signed [SCORE_W-1:0] s, logic last);
      bit              done;
      bit              emit;
      char_result_type res;
      if (class_ctr == 0 || s > step_max) begin
         step_max = s;
         step_win = class_ctr;
      end
      done = last || (class_ctr + 1 >= eff_classes(class_cfg));
      if (!done) begin
         class_ctr++;
         return;
      end
      emit = step_win > 0 && step_win < int'(key_cfg) && step_win != prev_win;
      if (emit || last) begin
         res.char_valid = emit;
         res.key_index  = emit ? step_win[IDX_W-1:0] : '0;
         res.best_score = emit ? step_max : '0;
         res.step_index = emit ? step_ctr[STEP_W-1:0] : '0;
         res.seq_end    = last;
         pending_chars.insert(pending_chars.size(), res);
      end
      // close the step
      if (last) begin
         prev_win = 0;
         step_ctr = 0;
      end else begin
         prev_win = step_win;
         if (step_ctr < DEF_MAX_STEPS - 1) step_ctr++;
      end
      class_ctr = 0;
      step_max  = {1'b1, {(SCORE_W-1){1'b0}}};
      step_win  = 0;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         burst = $urandom_range(30, 80);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SCORE_W-1:0] rand_score();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return {1'b1, {(SCORE_W-1){1'b0}}};
      if (r == 1) return {1'b0, {(SCORE_W-1){1'b1}}};
      return SCORE_W'($urandom());
   endfunction

   task automatic push_score(logic [SCORE_W-1:0] score, logic last, logic hold = 1'b0);
      score_item_type it;
      it.score = score;
      it.last  = last;
      it.hold  = hold;
      score_q.insert(score_q.size(), it);
      pushed_items++;
   endtask

   // well-formed sequence: at most one class planted per step, repeats and blanks favored
   task automatic push_sequence(int n, int steps, bit cut);
      int   target;
      int   prev_target;
      int   len;
      int   r;
      bit   plant;
      logic [SCORE_W-1:0] s;
      prev_target = 0;
      for (int st = 0; st < steps; st++) begin
         len = n;
         if (cut && st == steps - 1) len = $urandom_range(1, n > 64 ? 12 : n);
         r = $urandom_range(0, 9);
         if (r < 3) target = prev_target;
         else if (r < 5) target = 0;
         else target = $urandom_range(0, len - 1);
         plant = $urandom_range(0, 3) != 0;
         for (int c = 0; c < len; c++) begin
            s = (plant && c == target) ? SCORE_W'($urandom_range(20000, 32767)) : rand_score();
            push_score(s, st == steps - 1 && c == len - 1,
                       st == 0 && c == 0 && $urandom_range(0, 29) == 0);
         end
         prev_target = target;
      end
   endtask

   // block is idle once everything sent has come back and the pipe has drained
   task automatic wait_idle();
      while (score_q.size() != 0 || req_tvalid || pending_chars.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      if (idx == REG_CLASS_COUNT) class_cfg = value;
      else key_cfg = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic note_error(string what, char_result_type exp, char_result_type got);
      if (errors < 10) begin
         $display("%0t %s: expected char=%0d key=%0d score=%0d step=%0d end=%0d",
                  $time, what, exp.char_valid, exp.key_index, exp.best_score,
                  exp.step_index, exp.seq_end);
         $display("%0t %s: got char=%0d key=%0d score=%0d step=%0d end=%0d",
                  $time, what, got.char_valid, got.key_index, got.best_score,
                  got.step_index, got.seq_end);
      end
      errors++;
   endtask

   // score driver
   logic req_taken = 1'b0;
   int   send_gap = 0;
   int   send_burst = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (score_q.size() != 0 &&
                      !(score_q[0].hold && pending_chars.size() != 0)) begin
            req_tdata  <= REQ_DATA_W'(score_q[0].score);
            req_tlast  <= score_q[0].last;
            req_tvalid <= 1'b1;
            void'(score_q.pop_front());
            send_gap = pick_gap(send_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   int stall = 0;
   int stall_burst = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall = pick_gap(stall_burst);
      end
   end

   // monitor: predict on accepted scores, check accepted results
   always @(posedge clock) begin
      char_result_type got;
      char_result_type exp;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) decode_score(req_tdata[SCORE_W-1:0], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[IDX_W-1:0], rsp_tdata[IDX_W+SCORE_W-1:IDX_W],
                   rsp_tdata[IDX_W+SCORE_W+STEP_W-1:IDX_W+SCORE_W], rsp_tlast};
            if (pending_chars.size() == 0) begin
               note_error("result with none expected", '0, got);
            end else begin
               exp = pending_chars.pop_front();
               if (got.char_valid !== exp.char_valid || got.key_index !== exp.key_index ||
                   got.best_score !== exp.best_score || got.step_index !== exp.step_index ||
                   got.seq_end !== exp.seq_end)
                  note_error("result mismatch", exp, got);
            end
         end
      end
   end

   // stimulus
   initial begin
      int n;
      int r;
      int phase_end;
      int steps;
      int start_items;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: one class per step, nothing emitted, only end markers
      push_score(16'sd5, 1'b0);
      push_score(16'h8000, 1'b1);
      wait_idle();

      // three classes, keys below three
      write_csr(REG_CLASS_COUNT, 14'd3);
      write_csr(REG_KEY_COUNT, 14'd3);
      // tie at the top: first class wins
      push_score(16'h8000, 1'b0);
      push_score(16'h7fff, 1'b0);
      push_score(16'h7fff, 1'b0);
      // all equal: blank wins
      push_score(16'h0000, 1'b0, 1'b1);
      push_score(16'h0000, 1'b0);
      push_score(16'h0000, 1'b0);
      // repeat let through after the blank
      push_score(16'hffff, 1'b0);
      push_score(16'd100, 1'b0);
      push_score(16'h8000, 1'b0);
      // plain repeat, suppressed
      push_score(16'hfffb, 1'b0);
      push_score(16'd200, 1'b0);
      push_score(16'hfffb, 1'b0);
      push_score(16'd1, 1'b0);
      push_score(16'd2, 1'b0);
      push_score(16'd3, 1'b0);
      // end in mid-step
      push_score(16'd10, 1'b0);
      push_score(16'd20, 1'b1);
      wait_idle();

      // winner at or above key count is dropped
      write_csr(REG_KEY_COUNT, 14'd2);
      push_score(16'd0, 1'b0);
      push_score(16'd0, 1'b0);
      push_score(16'd9, 1'b1);
      wait_idle();

      // zero class count acts as one
      write_csr(REG_CLASS_COUNT, 14'd0);
      push_score(16'd3, 1'b0);
      push_score(16'd4, 1'b1);
      wait_idle();

      // random phases under changing settings
      start_items = pushed_items;
      while (pushed_items - start_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         if (r < 7) write_csr(REG_CLASS_COUNT, CFG_W'($urandom_range(1, 6)));
         else if (r == 7) write_csr(REG_CLASS_COUNT, 14'd0);
         else if (r == 8) write_csr(REG_CLASS_COUNT, CFG_W'($urandom_range(7, 40)));
         else write_csr(REG_CLASS_COUNT, $urandom_range(0, 1) ? 14'h3fff :
                                         CFG_W'($urandom_range(8192, 16383)));
         n = eff_classes(class_cfg);
         r = $urandom_range(0, 9);
         if (r < 6) write_csr(REG_KEY_COUNT, CFG_W'($urandom_range(0, n + 1)));
         else if (r < 8) write_csr(REG_KEY_COUNT, 14'h3fff);
         else if (r == 8) write_csr(REG_KEY_COUNT, 14'd0);
         else write_csr(REG_KEY_COUNT, CFG_W'($urandom()));
         phase_end = pushed_items + $urandom_range(40, 90);
         while (pushed_items < phase_end) begin
            if (n > 64) begin
               push_sequence(n, 1, 1'b1);
            end else begin
               steps = $urandom_range(1, (60 / n > 1) ? 60 / n : 1);
               push_sequence(n, steps, $urandom_range(0, 6) == 0);
            end
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("ctc_greedy_decoder_tb passed");
      end else begin
         $display("ctc_greedy_decoder_tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("ctc_greedy_decoder_tb failed");
      $finish;
   end

endmodule
